// ===== rtl/lennard_jones_pair_eval_assert.svh =====
// assertion helpers, clocked on clk and disabled during reset
`ifndef LENNARD_JONES_PAIR_EVAL_ASSERT_SVH
`define LENNARD_JONES_PAIR_EVAL_ASSERT_SVH
`define LJP_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lennard_jones_pair_eval: check failed");
`define LJP_ASSERT_DELAY(lbl, ante, n, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
	else $error("lennard_jones_pair_eval: check failed");
`endif

// ===== rtl/ljp_pkg.sv =====
package ljp_pkg;

	localparam int MUL_W = 64;
	localparam int DEN_W = 32;
	localparam int SQ_W  = 63;
	localparam int RES_W = 48;

	localparam logic [SQ_W-1:0]  MID_LIMIT = SQ_W'(1) << 62;
	localparam logic [RES_W-1:0] POS_LIMIT = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] NEG_LIMIT = {1'b1, {(RES_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_WELL_DEPTH,
		REG_ZERO_DISTANCE,
		REG_CUTOFF_RADIUS
	} reg_idx_t;

	typedef struct packed {
		logic             far;
		logic             zero;
		logic             mid;
		logic [DEN_W-1:0] r;
	} ctl_t;

	typedef struct packed {
		ctl_t            c;
		logic [SQ_W-1:0] v;
	} ctl_val_t;

	typedef struct packed {
		ctl_t c;
		logic gneg;
	} ctl_sgn_t;

	typedef struct packed {
		ctl_t             c;
		logic             eneg;
		logic             gneg;
		logic             eov;
		logic [RES_W-1:0] emag;
		logic             gpre;
	} grad_tag_t;

	typedef struct packed {
		logic            ov;
		logic [SQ_W-1:0] v;
	} sat_t;

	function automatic logic [RES_W-1:0] to_signed(input logic [RES_W-1:0] mag, input logic neg);
		return neg ? (~mag + RES_W'(1)) : mag;
	endfunction

endpackage

// ===== rtl/ljp_mul.sv =====
module ljp_mul #(
	parameter int TAG_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_i,
	input  logic [TAG_W-1:0]             tag_i,
	input  logic [ljp_pkg::MUL_W-1:0]    a_i,
	input  logic [ljp_pkg::MUL_W-1:0]    b_i,
	output logic                         vld_o,
	output logic [TAG_W-1:0]             tag_o,
	output logic [2*ljp_pkg::MUL_W-1:0]  prod_o
);
	import ljp_pkg::*;

	localparam int HALF = MUL_W / 2;

	logic             vld_s1, vld_s2, vld_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic [MUL_W-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [MUL_W:0]   mid_s2;
	logic [MUL_W-1:0] ll_s2, hh_s2;
	logic [2*MUL_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_i;
		ll_s1   <= a_i[HALF-1:0] * b_i[HALF-1:0];
		lh_s1   <= a_i[HALF-1:0] * b_i[MUL_W-1:HALF];
		hl_s1   <= a_i[MUL_W-1:HALF] * b_i[HALF-1:0];
		hh_s1   <= a_i[MUL_W-1:HALF] * b_i[MUL_W-1:HALF];
		tag_s2  <= tag_s1;
		mid_s2  <= {1'b0, lh_s1} + {1'b0, hl_s1};
		ll_s2   <= ll_s1;
		hh_s2   <= hh_s1;
		tag_s3  <= tag_s2;
		prod_s3 <= {hh_s2, ll_s2} + {{(HALF-1){1'b0}}, mid_s2, {HALF{1'b0}}};
	end

	assign vld_o  = vld_s3;
	assign tag_o  = tag_s3;
	assign prod_o = prod_s3;

endmodule

// ===== rtl/ljp_div.sv =====
module ljp_div #(
	parameter int QW    = 56,
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_i,
	input  logic [TAG_W-1:0]          tag_i,
	input  logic [ljp_pkg::DEN_W-1:0] rem_i,
	input  logic [QW-1:0]             num_i,
	input  logic [ljp_pkg::DEN_W-1:0] den_i,
	output logic                      vld_o,
	output logic [TAG_W-1:0]          tag_o,
	output logic [QW-1:0]             quo_o
);
	import ljp_pkg::*;

	logic             vld_s  [QW];
	logic [TAG_W-1:0] tag_s  [QW];
	logic [DEN_W-1:0] rem_s  [QW];
	logic [DEN_W-1:0] den_s  [QW];
	logic [QW-1:0]    work_s [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_step
		logic             src_vld;
		logic [TAG_W-1:0] src_tag;
		logic [DEN_W-1:0] src_rem;
		logic [DEN_W-1:0] src_den;
		logic [QW-1:0]    src_work;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign src_vld  = vld_i;
			assign src_tag  = tag_i;
			assign src_rem  = rem_i;
			assign src_den  = den_i;
			assign src_work = num_i;
		end else begin : g_next
			assign src_vld  = vld_s[k-1];
			assign src_tag  = tag_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_work = work_s[k-1];
		end

		assign trial = {src_rem, src_work[QW-1]};
		assign ge    = trial >= {1'b0, src_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k]  <= src_tag;
			den_s[k]  <= src_den;
			rem_s[k]  <= ge ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
			work_s[k] <= {src_work[QW-2:0], ge};
		end
	end

	assign vld_o = vld_s[QW-1];
	assign tag_o = tag_s[QW-1];
	assign quo_o = work_s[QW-1];

endmodule

// ===== rtl/lennard_jones_pair_eval.sv =====
// Throughput: one pair distance per cycle; busy stays low and results never wait.
// Latency is set by the two restoring dividers (sigma/r and gradient/r), one
// quotient bit per stage, plus six three-stage multipliers (the last two in parallel) and their clamp stages.
// Reset (arst_n low) clears every valid bit at once and loads the register defaults.
`include "lennard_jones_pair_eval_assert.svh"
module lennard_jones_pair_eval #(
	parameter int FRAC_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ljp_pkg::DEN_W-1:0]       pair_distance,
	output logic                            done,
	output logic signed [ljp_pkg::RES_W-1:0] pair_energy,
	output logic signed [ljp_pkg::RES_W-1:0] pair_gradient,
	output logic                            saturated,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import ljp_pkg::*;

	localparam int QW   = DEN_W + FRAC_BITS;
	localparam int GQ_W = RES_W;
	localparam int LAT  = QW + 70;
	localparam int PW   = 2 * MUL_W;

	logic [31:0] well_depth_q, zero_distance_q, cutoff_radius_q;
	logic        wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			well_depth_q    <= 32'd16777216;
			zero_distance_q <= 32'd16777216;
			cutoff_radius_q <= 32'hFFFF_FFFF;
		end else if (wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WELL_DEPTH:    well_depth_q    <= pwdata;
				REG_ZERO_DISTANCE: zero_distance_q <= pwdata;
				REG_CUTOFF_RADIUS: cutoff_radius_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WELL_DEPTH:    prdata = well_depth_q;
			REG_ZERO_DISTANCE: prdata = zero_distance_q;
			REG_CUTOFF_RADIUS: prdata = cutoff_radius_q;
			default:           prdata = '0;
		endcase
	end

	function automatic sat_t clamp_mid(input logic [PW-1:0] p);
		logic [PW-1:0] q;
		sat_t          res;
		q      = p >> FRAC_BITS;
		res.ov = q > {{(PW-SQ_W){1'b0}}, MID_LIMIT};
		res.v  = res.ov ? MID_LIMIT : q[SQ_W-1:0];
		return res;
	endfunction

	// sigma / r
	ctl_t          ctl_in;
	logic          d1_vld;
	ctl_t          d1_tag;
	logic [QW-1:0] d1_quo;

	always_comb begin
		ctl_in.far  = pair_distance > cutoff_radius_q;
		ctl_in.zero = pair_distance == '0;
		ctl_in.mid  = 1'b0;
		ctl_in.r    = pair_distance;
	end

	ljp_div #(.QW(QW), .TAG_W($bits(ctl_t))) u_div_s (
		.clk, .arst_n,
		.vld_i(start), .tag_i(ctl_in),
		.rem_i('0), .num_i({zero_distance_q, {FRAC_BITS{1'b0}}}), .den_i(pair_distance),
		.vld_o(d1_vld), .tag_o(d1_tag), .quo_o(d1_quo)
	);

	// s^2
	logic          m2_vld;
	ctl_val_t      m2_tag;
	logic [PW-1:0] m2_prod;
	sat_t          sat2;

	ljp_mul #(.TAG_W($bits(ctl_val_t))) u_mul_s2 (
		.clk, .arst_n,
		.vld_i(d1_vld), .tag_i({d1_tag, SQ_W'(d1_quo)}),
		.a_i(MUL_W'(d1_quo)), .b_i(MUL_W'(d1_quo)),
		.vld_o(m2_vld), .tag_o(m2_tag), .prod_o(m2_prod)
	);

	assign sat2 = clamp_mid(m2_prod);

	logic            vld_s1;
	ctl_t            ctl_s1;
	logic [SQ_W-1:0] sq1_s1, sq2_s1;

	// s^3
	logic          m3_vld;
	ctl_t          m3_tag;
	logic [PW-1:0] m3_prod;
	sat_t          sat3;

	ljp_mul #(.TAG_W($bits(ctl_t))) u_mul_s3 (
		.clk, .arst_n,
		.vld_i(vld_s1), .tag_i(ctl_s1),
		.a_i(MUL_W'(sq2_s1)), .b_i(MUL_W'(sq1_s1)),
		.vld_o(m3_vld), .tag_o(m3_tag), .prod_o(m3_prod)
	);

	assign sat3 = clamp_mid(m3_prod);

	logic            vld_s2;
	ctl_t            ctl_s2;
	logic [SQ_W-1:0] sq3_s2;

	// s^6
	logic          m6_vld;
	ctl_t          m6_tag;
	logic [PW-1:0] m6_prod;
	sat_t          sat6;

	ljp_mul #(.TAG_W($bits(ctl_t))) u_mul_s6 (
		.clk, .arst_n,
		.vld_i(vld_s2), .tag_i(ctl_s2),
		.a_i(MUL_W'(sq3_s2)), .b_i(MUL_W'(sq3_s2)),
		.vld_o(m6_vld), .tag_o(m6_tag), .prod_o(m6_prod)
	);

	assign sat6 = clamp_mid(m6_prod);

	logic            vld_s3;
	ctl_t            ctl_s3;
	logic [SQ_W-1:0] sq6_s3;

	// s^12
	logic          m12_vld;
	ctl_val_t      m12_tag;
	logic [PW-1:0] m12_prod;
	sat_t          sat12;

	ljp_mul #(.TAG_W($bits(ctl_val_t))) u_mul_s12 (
		.clk, .arst_n,
		.vld_i(vld_s3), .tag_i({ctl_s3, sq6_s3}),
		.a_i(MUL_W'(sq6_s3)), .b_i(MUL_W'(sq6_s3)),
		.vld_o(m12_vld), .tag_o(m12_tag), .prod_o(m12_prod)
	);

	assign sat12 = clamp_mid(m12_prod);

	logic            vld_s4;
	ctl_t            ctl_s4;
	logic [SQ_W-1:0] sq6_s4, sq12_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= m2_vld;
			vld_s2 <= m3_vld;
			vld_s3 <= m6_vld;
			vld_s4 <= m12_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= '{far: m2_tag.c.far, zero: m2_tag.c.zero,
		             mid: m2_tag.c.mid | sat2.ov, r: m2_tag.c.r};
		sq1_s1  <= m2_tag.v;
		sq2_s1  <= sat2.v;
		ctl_s2  <= '{far: m3_tag.far, zero: m3_tag.zero,
		             mid: m3_tag.mid | sat3.ov, r: m3_tag.r};
		sq3_s2  <= sat3.v;
		ctl_s3  <= '{far: m6_tag.far, zero: m6_tag.zero,
		             mid: m6_tag.mid | sat6.ov, r: m6_tag.r};
		sq6_s3  <= sat6.v;
		ctl_s4  <= '{far: m12_tag.c.far, zero: m12_tag.c.zero,
		             mid: m12_tag.c.mid | sat12.ov, r: m12_tag.c.r};
		sq6_s4  <= m12_tag.v;
		sq12_s4 <= sat12.v;
	end

	// differences and scaled well depth
	logic [SQ_W:0]   twice;
	logic            vld_s5, eneg_s5, gneg_s5;
	ctl_t            ctl_s5;
	logic [SQ_W-1:0] de_s5;
	logic [SQ_W:0]   dg_s5;
	logic [33:0]     e4_s5;
	logic [36:0]     e24_s5;

	assign twice = {sq12_s4, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl_s4;
		eneg_s5 <= sq12_s4 < sq6_s4;
		de_s5   <= (sq12_s4 < sq6_s4) ? (sq6_s4 - sq12_s4) : (sq12_s4 - sq6_s4);
		gneg_s5 <= {1'b0, sq6_s4} < twice;
		dg_s5   <= ({1'b0, sq6_s4} < twice) ? (twice - {1'b0, sq6_s4})
		                                     : ({1'b0, sq6_s4} - twice);
		e4_s5   <= {well_depth_q, 2'b00};
		e24_s5  <= 37'({well_depth_q, 4'b0000}) + 37'({well_depth_q, 3'b000});
	end

	// 4*eps*d and 24*eps*d
	logic          me_vld, me_tag;
	logic [PW-1:0] me_prod;
	logic          mg_vld;
	ctl_sgn_t      mg_tag;
	logic [PW-1:0] mg_prod;

	ljp_mul #(.TAG_W(1)) u_mul_e (
		.clk, .arst_n,
		.vld_i(vld_s5), .tag_i(eneg_s5),
		.a_i(MUL_W'(e4_s5)), .b_i(MUL_W'(de_s5)),
		.vld_o(me_vld), .tag_o(me_tag), .prod_o(me_prod)
	);

	ljp_mul #(.TAG_W($bits(ctl_sgn_t))) u_mul_g (
		.clk, .arst_n,
		.vld_i(vld_s5), .tag_i({ctl_s5, gneg_s5}),
		.a_i(MUL_W'(e24_s5)), .b_i(MUL_W'(dg_s5)),
		.vld_o(mg_vld), .tag_o(mg_tag), .prod_o(mg_prod)
	);

	logic [PW-1:0]    eq;
	logic [RES_W-1:0] elim;
	logic             eov;
	logic             vld_s6;
	grad_tag_t        gt_s6;
	logic [DEN_W-1:0] grem_s6;
	logic [GQ_W-1:0]  glo_s6;

	assign eq   = me_prod >> FRAC_BITS;
	assign elim = me_tag ? NEG_LIMIT : POS_LIMIT;
	assign eov  = eq > {{(PW-RES_W){1'b0}}, elim};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= me_vld & mg_vld;
		end
	end

	always_ff @(posedge clk) begin
		gt_s6.c    <= mg_tag.c;
		gt_s6.eneg <= me_tag;
		gt_s6.gneg <= mg_tag.gneg;
		gt_s6.eov  <= eov;
		gt_s6.emag <= eov ? elim : eq[RES_W-1:0];
		gt_s6.gpre <= mg_prod[PW-1:GQ_W] >= {{(PW-GQ_W-DEN_W){1'b0}}, mg_tag.c.r};
		grem_s6    <= mg_prod[GQ_W+DEN_W-1:GQ_W];
		glo_s6     <= mg_prod[GQ_W-1:0];
	end

	// gradient / r
	logic            d2_vld;
	grad_tag_t       d2_tag;
	logic [GQ_W-1:0] d2_quo;

	ljp_div #(.QW(GQ_W), .TAG_W($bits(grad_tag_t))) u_div_g (
		.clk, .arst_n,
		.vld_i(vld_s6), .tag_i(gt_s6),
		.rem_i(grem_s6), .num_i(glo_s6), .den_i(gt_s6.c.r),
		.vld_o(d2_vld), .tag_o(d2_tag), .quo_o(d2_quo)
	);

	logic [RES_W-1:0] glim, gmag, e_nx, g_nx;
	logic             gov, sat_nx;

	assign glim = d2_tag.gneg ? NEG_LIMIT : POS_LIMIT;
	assign gov  = d2_tag.gpre | (d2_quo > glim);
	assign gmag = gov ? glim : d2_quo;

	always_comb begin
		if (d2_tag.c.far) begin
			e_nx   = '0;
			g_nx   = '0;
			sat_nx = 1'b0;
		end else if (d2_tag.c.zero) begin
			e_nx   = POS_LIMIT;
			g_nx   = NEG_LIMIT;
			sat_nx = 1'b1;
		end else if (well_depth_q == '0) begin
			e_nx   = '0;
			g_nx   = '0;
			sat_nx = 1'b0;
		end else if (d2_tag.c.mid) begin
			e_nx   = POS_LIMIT;
			g_nx   = NEG_LIMIT;
			sat_nx = 1'b1;
		end else begin
			e_nx   = to_signed(d2_tag.emag, d2_tag.eneg);
			g_nx   = to_signed(gmag, d2_tag.gneg);
			sat_nx = d2_tag.eov | gov;
		end
	end

	logic             done_s7, sat_s7;
	logic [RES_W-1:0] energy_s7, gradient_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		energy_s7   <= e_nx;
		gradient_s7 <= g_nx;
		sat_s7      <= sat_nx;
	end

	assign done          = done_s7;
	assign pair_energy   = energy_s7;
	assign pair_gradient = gradient_s7;
	assign saturated     = sat_s7;

	`LJP_ASSERT_DELAY(a_word_out, start, LAT, done)
	`LJP_ASSERT_IMPL(a_word_src, done, $past(start, LAT))
	`LJP_ASSERT_DELAY(a_zero_r, start && pair_distance == '0, LAT, saturated && pair_gradient == NEG_LIMIT)
	`LJP_ASSERT_DELAY(a_far_r, start && pair_distance > cutoff_radius_q, LAT, pair_energy == '0 && !saturated)

endmodule
